### sv/sitda_pkg.sv
package sitda_pkg;

   localparam int ValueWidth    = 32;
   localparam int NumDigits     = 10;
   localparam int BcdWidth      = 4 * NumDigits;
   localparam int CharWidth     = 6;
   localparam int BitCountWidth = $clog2(ValueWidth);
   localparam int DigCountWidth = $clog2(NumDigits + 1);

   localparam logic [CharWidth-1:0]     CharZero    = 6'd48;
   localparam logic [CharWidth-1:0]     CharMinus   = 6'd45;
   localparam logic [BitCountWidth-1:0] LastBit     = BitCountWidth'(ValueWidth - 1);
   localparam logic [DigCountWidth-1:0] DigitsAll   = DigCountWidth'(NumDigits);
   localparam logic [DigCountWidth-1:0] DigitsOne   = DigCountWidth'(1);

   typedef enum logic [1:0] {
      CV_IDLE,
      CV_RUN,
      CV_DONE
   } conv_state_type;

   typedef enum logic [1:0] {
      EM_IDLE,
      EM_SIGN,
      EM_SKIP,
      EM_DIGIT
   } emit_state_type;

   typedef struct packed {
      logic                valid;
      logic                neg;
      logic [BcdWidth-1:0] bcd;
   } word_type;

endpackage

### sv/sitda_dabble.sv
module sitda_dabble (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [sitda_pkg::ValueWidth-1:0]    req_value,
   output sitda_pkg::word_type                 word,
   input  logic                                word_take
);

   sitda_pkg::conv_state_type               state_ff, state_in;
   logic [sitda_pkg::ValueWidth-1:0]        mag_ff, mag_in;
   logic [sitda_pkg::BcdWidth-1:0]          bcd_ff, bcd_in, bcd_adj;
   logic                                    neg_ff, neg_in;
   logic [sitda_pkg::BitCountWidth-1:0]     cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sitda_pkg::CV_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
   end

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int d = 0; d < sitda_pkg::NumDigits; d++) begin
         if (bcd_ff[4*d +: 4] >= 4'd5) begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4] + 4'd3;
         end else begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4];
         end
      end
   end

   always_comb begin
      state_in   = state_ff;
      mag_in     = mag_ff;
      bcd_in     = bcd_ff;
      neg_in     = neg_ff;
      cnt_in     = cnt_ff;
      req_stall  = 1'b1;
      word.valid = 1'b0;
      word.neg   = neg_ff;
      word.bcd   = bcd_ff;
      unique case (state_ff)
         sitda_pkg::CV_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               neg_in   = req_value[sitda_pkg::ValueWidth-1];
               mag_in   = req_value[sitda_pkg::ValueWidth-1] ? (~req_value + 1'b1) : req_value;
               bcd_in   = '0;
               cnt_in   = '0;
               state_in = sitda_pkg::CV_RUN;
            end
         end
         sitda_pkg::CV_RUN: begin
            bcd_in = {bcd_adj[sitda_pkg::BcdWidth-2:0], mag_ff[sitda_pkg::ValueWidth-1]};
            mag_in = {mag_ff[sitda_pkg::ValueWidth-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == sitda_pkg::LastBit) begin
               state_in = sitda_pkg::CV_DONE;
            end
         end
         sitda_pkg::CV_DONE: begin
            word.valid = 1'b1;
            if (word_take) begin
               state_in = sitda_pkg::CV_IDLE;
            end
         end
         default: begin
            state_in = sitda_pkg::CV_IDLE;
         end
      endcase
   end

endmodule

### sv/sitda_emit.sv
module sitda_emit (
   input  logic                                clock,
   input  logic                                reset,
   input  sitda_pkg::word_type                 word,
   output logic                                word_take,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [sitda_pkg::CharWidth-1:0]     rsp_character,
   output logic                                rsp_last
);

   sitda_pkg::emit_state_type               state_ff, state_in;
   logic [sitda_pkg::BcdWidth-1:0]          bcd_ff, bcd_in;
   logic [sitda_pkg::DigCountWidth-1:0]     cnt_ff, cnt_in;
   logic                                    valid_ff, valid_in;
   logic [sitda_pkg::CharWidth-1:0]         char_ff, char_in;
   logic                                    last_ff, last_in;
   logic [3:0]                              top;
   logic                                    out_free;
   logic                                    final_digit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sitda_pkg::EM_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      bcd_ff  <= bcd_in;
      cnt_ff  <= cnt_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign top           = bcd_ff[sitda_pkg::BcdWidth-1 -: 4];
   assign out_free      = !valid_ff || !rsp_stall;
   assign final_digit   = (cnt_ff == sitda_pkg::DigitsOne);
   assign rsp_valid     = valid_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;

   always_comb begin
      state_in  = state_ff;
      bcd_in    = bcd_ff;
      cnt_in    = cnt_ff;
      char_in   = char_ff;
      last_in   = last_ff;
      valid_in  = valid_ff && rsp_stall;
      word_take = 1'b0;
      unique case (state_ff)
         sitda_pkg::EM_IDLE: begin
            if (word.valid) begin
               word_take = 1'b1;
               bcd_in    = word.bcd;
               cnt_in    = sitda_pkg::DigitsAll;
               state_in  = word.neg ? sitda_pkg::EM_SIGN : sitda_pkg::EM_SKIP;
            end
         end
         sitda_pkg::EM_SIGN: begin
            if (out_free) begin
               valid_in = 1'b1;
               char_in  = sitda_pkg::CharMinus;
               last_in  = 1'b0;
               state_in = sitda_pkg::EM_SKIP;
            end
         end
         sitda_pkg::EM_SKIP: begin
            if (top == 4'd0 && !final_digit) begin
               bcd_in = {bcd_ff[sitda_pkg::BcdWidth-5:0], 4'd0};
               cnt_in = cnt_ff - 1'b1;
            end else begin
               state_in = sitda_pkg::EM_DIGIT;
            end
         end
         sitda_pkg::EM_DIGIT: begin
            if (out_free) begin
               valid_in = 1'b1;
               char_in  = sitda_pkg::CharZero + {2'b00, top};
               last_in  = final_digit;
               bcd_in   = {bcd_ff[sitda_pkg::BcdWidth-5:0], 4'd0};
               cnt_in   = cnt_ff - 1'b1;
               if (final_digit) begin
                  state_in = sitda_pkg::EM_IDLE;
               end
            end
         end
         default: begin
            state_in = sitda_pkg::EM_IDLE;
         end
      endcase
   end

endmodule

### sv/signed_int_to_decimal_ascii_core.sv
// Channel   Direction  Ports                                Payload
// request   in         req_valid, req_stall, req_value      32-bit signed integer
// response  out        rsp_valid, rsp_stall, rsp_character, 6-bit ASCII code and
//                      rsp_last                             end-of-text mark
//
// A request goes through bit-serial shift-and-add-3 conversion and is handed
// to the character stage, which sends a minus sign for a negative value, drops
// leading zeros and then sends the digits one character at a time. Conversion
// of the next request overlaps the characters of the previous one. Reset is
// synchronous and clears the state machines and the response valid flag. A stalled
// response holds in its output register; conversion runs on meanwhile.
module signed_int_to_decimal_ascii_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [sitda_pkg::ValueWidth-1:0]    req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [sitda_pkg::CharWidth-1:0]     rsp_character,
   output logic                                rsp_last
);

   sitda_pkg::word_type word;
   logic                word_take;

   sitda_dabble u_dabble (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_value (req_value),
      .word      (word),
      .word_take (word_take)
   );

   sitda_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .word          (word),
      .word_take     (word_take),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule

### sv/sitda_checker.sv
module sitda_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [sitda_pkg::CharWidth-1:0]     rsp_character,
   input logic                                rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_character) && $stable(rsp_last))
      else $error("stalled response changed");

   a_char_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_character == sitda_pkg::CharMinus) ||
                    (rsp_character >= sitda_pkg::CharZero &&
                     rsp_character <= sitda_pkg::CharZero + 6'd9))
      else $error("response is not a minus sign or a digit");

   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_character == sitda_pkg::CharMinus |-> !rsp_last)
      else $error("minus sign ends a text");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while converting");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind signed_int_to_decimal_ascii_core sitda_checker u_sitda_checker (.*);
